@@ hdl/atg_pkg.sv @@
// ============================================================================
// atg_pkg
// Types and constants of the triangle tone generator with ADSR envelope.
// ============================================================================
package atg_pkg;

    localparam int PHASE_W  = 32;   // Q0.32 phase and phase step
    localparam int SAMPLE_W = 16;   // signed audio sample
    localparam int CFG_W    = 16;   // widest configuration register
    localparam int PEAK_W   = 15;
    localparam int ENV_W    = 17;   // envelope, full scale is exactly 2^16
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_LENGTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_LENGTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_AMPLITUDE = 3'd5;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0]  RST_ATTACK_LENGTH  = 16'd220;
    localparam logic [CFG_W-1:0]  RST_DECAY_LENGTH   = 16'd1102;
    localparam logic [CFG_W-1:0]  RST_SUSTAIN_LEVEL  = 16'd42598;
    localparam logic [CFG_W-1:0]  RST_RELEASE_LENGTH = 16'd4410;
    localparam logic [CFG_W-1:0]  RST_NOTE_LENGTH    = 16'd16537;
    localparam logic [PEAK_W-1:0] RST_PEAK_AMPLITUDE = 15'd22000;

    typedef struct packed {
        logic               start_req;
        logic [PHASE_W-1:0] phase_step;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       active;
    } out_item_t;

endpackage

@@ hdl/adsr_triangle_tone_generator.sv @@
// ============================================================================
// adsr_triangle_tone_generator
// Triangle oscillator with a piecewise linear attack/decay/sustain/release
// envelope, one output sample per input transfer.
// ============================================================================
// One input transfer is one sample period and produces exactly one output
// transfer. The block works on one sample at a time and holds in_stall high
// until the sample has been loaded into the output register. One 32x17
// multiplier and a 17-step restoring divider are shared: the divider runs one
// quotient bit per cycle, and the attack ramp skips the ST_NUM step that forms
// the dividend. When the envelope is flat (sustain, or a release that has run
// out) the divider is skipped, and when no note is sounding a sample goes from
// ST_CHECK straight to ST_FIN. Each sample also passes through the idle state,
// and the last step waits while a previous result is still stalled in the
// output register. Configuration registers are written through
// cfg_wr_en/cfg_index/cfg_data and take effect as soon as they are written,
// so a write during a sample can change that sample.
module adsr_triangle_tone_generator
    import atg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data
);

    localparam int DIV_STEPS = ENV_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int NUM_W     = CFG_W + ENV_W;         // dividend width
    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = ENV_W;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int MAG_W     = PHASE_W + 1;
    localparam int TRI_W     = PHASE_W + 3;
    localparam int ACC_W     = PROD_W + 16;
    localparam int ACC_SHIFT = PHASE_W + 16;
    localparam int RES_W     = ACC_W - ACC_SHIFT;

    localparam logic [ENV_W-1:0] ENV_FULL  = 17'h10000;
    localparam logic [TRI_W-1:0] TRI_ONE   = 35'h1_0000_0000;
    localparam logic [TRI_W-1:0] TRI_THREE = 35'h3_0000_0000;
    localparam logic [RES_W-1:0] RES_MAX   = 17'h07FFF;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_NUM, ST_DIV, ST_ENVP, ST_MLO, ST_MHI, ST_SUM, ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        SEG_ATTACK, SEG_DECAY, SEG_RELEASE
    } seg_t;

    state_t              state_reg, state_next;
    seg_t                seg_reg, seg_next;

    logic [CFG_W-1:0]    attack_reg, attack_next;
    logic [CFG_W-1:0]    decay_reg, decay_next;
    logic [CFG_W-1:0]    sustain_reg, sustain_next;
    logic [CFG_W-1:0]    release_reg, release_next;
    logic [CFG_W-1:0]    note_reg, note_next;
    logic [PEAK_W-1:0]   peak_reg, peak_next;

    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [PHASE_W-1:0]  step_reg, step_next;
    logic [CFG_W-1:0]    idx_reg, idx_next;
    logic                playing_reg, playing_next;
    logic                act_reg, act_next;
    logic                neg_reg, neg_next;

    logic [CFG_W-1:0]    div_reg, div_next;
    logic [CFG_W-1:0]    rem_reg, rem_next;
    logic [ENV_W-1:0]    low_reg, low_next;
    logic [ENV_W-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ENV_W-1:0]    env_reg, env_next;
    logic [MUL_A_W-1:0]  escale_reg, escale_next;
    logic [MAG_W-1:0]    mag_reg, mag_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;

    logic                out_valid_reg, out_valid_next;
    out_item_t           out_data_reg, out_data_next;

    // shared multiplier
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [PROD_W-1:0]   prod;

    // envelope segment decode
    logic [ENV_W-1:0]    ad_end;
    logic [CFG_W-1:0]    rel_begin;
    logic [CFG_W-1:0]    rel_pos;
    logic                note_on;

    // divider step
    logic [ENV_W-1:0]    trial;
    logic                trial_ge;
    logic [ENV_W-1:0]    trial_diff;
    logic [ENV_W-1:0]    quo_step;

    // triangle
    logic [TRI_W-1:0]    p4;
    logic [TRI_W-1:0]    tri_mag;
    logic                tri_neg;

    // output value
    logic [RES_W-1:0]    res_raw;
    logic [SAMPLE_W-1:0] res_sat;
    logic [CFG_W-1:0]    idx_inc;

    assign ad_end    = {1'b0, attack_reg} + {1'b0, decay_reg};
    assign rel_begin = (release_reg > note_reg) ? '0 : note_reg - release_reg;
    assign rel_pos   = idx_reg - rel_begin;
    assign note_on   = playing_reg && (idx_reg < note_reg);

    assign trial      = {rem_reg, low_reg[ENV_W-1]};
    assign trial_ge   = trial >= {1'b0, div_reg};
    assign trial_diff = trial - {1'b0, div_reg};
    assign quo_step   = {quo_reg[ENV_W-2:0], trial_ge};

    assign p4 = {1'b0, phase_reg, 2'b00};

    assign res_raw = acc_reg[ACC_W-1:ACC_SHIFT];
    assign res_sat = (res_raw > RES_MAX) ? RES_MAX[SAMPLE_W-1:0] : res_raw[SAMPLE_W-1:0];
    assign idx_inc = idx_reg + 16'd1;

    always_comb
    begin
        case (state_reg)
            ST_NUM:
            begin
                if (seg_reg == SEG_DECAY)
                begin
                    mul_a = {15'd0, ENV_FULL - {1'b0, sustain_reg}};
                    mul_b = {1'b0, idx_reg - attack_reg};
                end
                else
                begin
                    mul_a = {16'd0, sustain_reg};
                    mul_b = {1'b0, release_reg - rel_pos};
                end
            end
            ST_ENVP:
            begin
                mul_a = {15'd0, env_reg};
                mul_b = {2'd0, peak_reg};
            end
            ST_MLO:
            begin
                mul_a = escale_reg;
                mul_b = {1'b0, mag_reg[15:0]};
            end
            ST_MHI:
            begin
                mul_a = escale_reg;
                mul_b = mag_reg[MAG_W-1:16];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb
    begin
        if (!phase_reg[PHASE_W-1])
        begin
            if (p4 >= TRI_ONE)
            begin
                tri_mag = p4 - TRI_ONE;
                tri_neg = 1'b0;
            end
            else
            begin
                tri_mag = TRI_ONE - p4;
                tri_neg = 1'b1;
            end
        end
        else
        begin
            if (p4 <= TRI_THREE)
            begin
                tri_mag = TRI_THREE - p4;
                tri_neg = 1'b0;
            end
            else
            begin
                tri_mag = p4 - TRI_THREE;
                tri_neg = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        seg_next       = seg_reg;
        attack_next    = attack_reg;
        decay_next     = decay_reg;
        sustain_next   = sustain_reg;
        release_next   = release_reg;
        note_next      = note_reg;
        peak_next      = peak_reg;
        phase_next     = phase_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        playing_next   = playing_reg;
        act_next       = act_reg;
        neg_next       = neg_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        low_next       = low_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        env_next       = env_reg;
        escale_next    = escale_reg;
        mag_next       = mag_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_ATTACK_LENGTH:  attack_next  = cfg_data;
                CFG_DECAY_LENGTH:   decay_next   = cfg_data;
                CFG_SUSTAIN_LEVEL:  sustain_next = cfg_data;
                CFG_RELEASE_LENGTH: release_next = cfg_data;
                CFG_NOTE_LENGTH:    note_next    = cfg_data;
                CFG_PEAK_AMPLITUDE: peak_next    = cfg_data[PEAK_W-1:0];
                default: ;
            endcase
        end

        // drop the output once its transfer completes
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.start_req)
                    begin
                        phase_next   = '0;
                        step_next    = in_data.phase_step;
                        idx_next     = '0;
                        playing_next = 1'b1;
                    end
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                cnt_next = CNT_W'(DIV_STEPS - 1);
                if (!note_on)
                begin
                    playing_next = 1'b0;
                    act_next     = 1'b0;
                    state_next   = ST_FIN;
                end
                else
                begin
                    act_next   = 1'b1;
                    phase_next = phase_reg + step_reg;
                    if (idx_reg < attack_reg)
                    begin
                        // dividend is idx * 2^16
                        seg_next   = SEG_ATTACK;
                        div_next   = attack_reg;
                        rem_next   = {1'b0, idx_reg[CFG_W-1:1]};
                        low_next   = {idx_reg[0], 16'd0};
                        state_next = ST_DIV;
                    end
                    else if ({1'b0, idx_reg} < ad_end)
                    begin
                        seg_next   = SEG_DECAY;
                        div_next   = decay_reg;
                        state_next = ST_NUM;
                    end
                    else if (idx_reg < rel_begin)
                    begin
                        env_next   = {1'b0, sustain_reg};
                        state_next = ST_ENVP;
                    end
                    else if (release_reg == '0 || rel_pos >= release_reg)
                    begin
                        env_next   = '0;
                        state_next = ST_ENVP;
                    end
                    else
                    begin
                        seg_next   = SEG_RELEASE;
                        div_next   = release_reg;
                        state_next = ST_NUM;
                    end
                end
            end

            ST_NUM:
            begin
                rem_next   = prod[NUM_W-1:ENV_W];
                low_next   = prod[ENV_W-1:0];
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                // one quotient bit per cycle, partial remainder stays below divisor
                rem_next = trial_ge ? trial_diff[CFG_W-1:0] : trial[CFG_W-1:0];
                low_next = {low_reg[ENV_W-2:0], 1'b0};
                quo_next = quo_step;
                if (cnt_reg == '0)
                begin
                    env_next   = (seg_reg == SEG_DECAY) ? ENV_FULL - quo_step : quo_step;
                    state_next = ST_ENVP;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end

            ST_ENVP:
            begin
                escale_next = prod[MUL_A_W-1:0];
                mag_next    = tri_mag[MAG_W-1:0];
                neg_next    = tri_neg;
                state_next  = ST_MLO;
            end

            ST_MLO:
            begin
                acc_next   = {16'd0, prod};
                state_next = ST_MHI;
            end

            ST_MHI:
            begin
                prod_next  = prod;
                state_next = ST_SUM;
            end

            ST_SUM:
            begin
                acc_next   = acc_reg + {prod_reg, 16'd0};
                state_next = ST_FIN;
            end

            ST_FIN:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next       = 1'b1;
                    out_data_next.active = act_reg;
                    if (act_reg)
                    begin
                        out_data_next.sample = neg_reg ? -res_sat : res_sat;
                        idx_next             = idx_inc;
                        if (idx_inc >= note_reg)
                            playing_next = 1'b0;
                    end
                    else
                    begin
                        out_data_next.sample = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seg_reg       <= SEG_ATTACK;
            attack_reg    <= RST_ATTACK_LENGTH;
            decay_reg     <= RST_DECAY_LENGTH;
            sustain_reg   <= RST_SUSTAIN_LEVEL;
            release_reg   <= RST_RELEASE_LENGTH;
            note_reg      <= RST_NOTE_LENGTH;
            peak_reg      <= RST_PEAK_AMPLITUDE;
            phase_reg     <= '0;
            step_reg      <= '0;
            idx_reg       <= '0;
            playing_reg   <= 1'b0;
            act_reg       <= 1'b0;
            neg_reg       <= 1'b0;
            div_reg       <= '0;
            rem_reg       <= '0;
            low_reg       <= '0;
            quo_reg       <= '0;
            cnt_reg       <= '0;
            env_reg       <= '0;
            escale_reg    <= '0;
            mag_reg       <= '0;
            prod_reg      <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            seg_reg       <= seg_next;
            attack_reg    <= attack_next;
            decay_reg     <= decay_next;
            sustain_reg   <= sustain_next;
            release_reg   <= release_next;
            note_reg      <= note_next;
            peak_reg      <= peak_next;
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            playing_reg   <= playing_next;
            act_reg       <= act_next;
            neg_reg       <= neg_next;
            div_reg       <= div_next;
            rem_reg       <= rem_next;
            low_reg       <= low_next;
            quo_reg       <= quo_next;
            cnt_reg       <= cnt_next;
            env_reg       <= env_next;
            escale_reg    <= escale_next;
            mag_reg       <= mag_next;
            prod_reg      <= prod_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
